// ===== rtl/dgs_pkg.sv =====
// ----------------------------------------------------------------------------
// dgs_pkg
// Shared types and constants of the depth gradient shading unit.
// ----------------------------------------------------------------------------
package dgs_pkg;

    // defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int DEPTH_BITS_DEF = 8;

    // configuration port
    localparam int CFG_BITS       = 10;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_BITS-1:0]       DIM_RESET        = 10'd512;
    localparam logic [CFG_BITS-1:0]       DIM_MIN          = 10'd3;
    localparam logic [CFG_BITS-1:0]       HEIGHT_LIMIT     = 10'd512;

    // row counter holds 0 .. HEIGHT_LIMIT-1
    localparam int ROW_BITS = 9;

    // stream payload widths
    localparam int DEPTH_FIELD_BITS = 8;
    localparam int SHADE_BITS       = 8;
    localparam int SHADE_IDX_BITS   = $clog2(SHADE_BITS);
    localparam int SHADE_SQ_BITS    = 2 * SHADE_BITS;

    // g*g*(4*s) <= 1020^2 reduces to g*g*s <= 1020^2/4, s = tx^2 + ty^2 + 4
    localparam int SHADE_LIMIT = 1020 * 1020 / 4;
    localparam int GRAD_BIAS   = 4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // what the front decided about one pixel
    typedef struct packed {
        logic emit;       // a row above exists, so a result goes out
        logic interior;   // shade is computed, else it is 0
        logic last_row;   // border pixel of the last row follows
        logic last_col;   // last column, also: no right neighbor
    } pix_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_OUT_PIXEL,
        ST_OUT_BORDER
    } back_state_t;

endpackage

// ===== rtl/dgs_queue.sv =====
// ----------------------------------------------------------------------------
// dgs_queue
// Small register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module dgs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(dgs_pkg::QUEUE_DEPTH);
    localparam int CNTW = $clog2(dgs_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [dgs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNTW'(dgs_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(dgs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(dgs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dgs_front.sv =====
// ----------------------------------------------------------------------------
// dgs_front
// Holds the frame size, tracks the raster position and classifies each pixel.
// ----------------------------------------------------------------------------
module dgs_front #(
    parameter int MAX_WIDTH  = dgs_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dgs_pkg::DEPTH_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [dgs_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [dgs_pkg::CFG_BITS-1:0]            cfg_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [dgs_pkg::DEPTH_FIELD_BITS-1:0]    s_tdata,
    input  logic                                    s_tuser,
    output logic                                    push,
    output logic [DEPTH_BITS-1:0]                   push_depth,
    output logic [$clog2(MAX_WIDTH)-1:0]            push_x,
    output dgs_pkg::pix_class_t                     push_class,
    input  logic                                    queue_full
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WW > dgs_pkg::CFG_BITS) ? WW : dgs_pkg::CFG_BITS;
    localparam int HW  = dgs_pkg::CFG_BITS;
    localparam int RW  = dgs_pkg::ROW_BITS;

    logic [dgs_pkg::CFG_BITS-1:0] width_reg;
    logic [dgs_pkg::CFG_BITS-1:0] height_reg;
    logic [AW-1:0]                col_reg, col_next;
    logic [RW-1:0]                row_reg, row_next;

    logic [CW-1:0] w_raw, w_used;
    logic [HW-1:0] h_used;
    logic [CW-1:0] c;
    logic [HW-1:0] r;
    logic          last_col;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dgs_pkg::DIM_RESET;
            height_reg <= dgs_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dgs_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == dgs_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // frame size saturated to the supported range
    always_comb
    begin
        w_raw = CW'(width_reg);
        if (w_raw < CW'(dgs_pkg::DIM_MIN))
        begin
            w_used = CW'(dgs_pkg::DIM_MIN);
        end
        else if (w_raw > CW'(MAX_WIDTH))
        begin
            w_used = CW'(MAX_WIDTH);
        end
        else
        begin
            w_used = w_raw;
        end

        if (height_reg < dgs_pkg::DIM_MIN)
        begin
            h_used = dgs_pkg::DIM_MIN;
        end
        else if (height_reg > dgs_pkg::HEIGHT_LIMIT)
        begin
            h_used = dgs_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            h_used = height_reg;
        end
    end

    // position of this pixel, with wrap after a size change
    always_comb
    begin
        c = CW'(col_reg);
        r = HW'(row_reg);
        if (s_tuser)
        begin
            c = '0;
            r = '0;
        end
        if (c >= w_used)
        begin
            c = '0;
            r = r + 1'b1;
        end
        if (r >= h_used)
        begin
            r = '0;
        end

        last_col = ((c + 1'b1) == w_used);

        if (last_col)
        begin
            col_next = '0;
            row_next = ((r + 1'b1) >= h_used) ? '0 : RW'(r + 1'b1);
        end
        else
        begin
            col_next = AW'(c + 1'b1);
            row_next = RW'(r);
        end

        push_x                = AW'(c);
        push_depth            = DEPTH_BITS'(s_tdata);
        push_class.emit       = (r != '0);
        push_class.last_row   = (r == h_used - 1'b1);
        push_class.last_col   = last_col;
        push_class.interior   = (c != '0) && !last_col && (r != '0) && (r != HW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/dgs_back.sv =====
// ----------------------------------------------------------------------------
// dgs_back
// Line buffers, central differences, bit-serial inverse root and result output.
// ----------------------------------------------------------------------------
module dgs_back #(
    parameter int MAX_WIDTH  = dgs_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dgs_pkg::DEPTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              queue_empty,
    output logic                              pop,
    input  logic [DEPTH_BITS-1:0]             pop_depth,
    input  logic [$clog2(MAX_WIDTH)-1:0]      pop_x,
    input  dgs_pkg::pix_class_t               pop_class,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dgs_pkg::SHADE_BITS-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int DB  = DEPTH_BITS;
    localparam int SQW = 2 * DB;
    localparam int SW  = 2 * DB + 1;
    localparam int GW  = dgs_pkg::SHADE_BITS;
    localparam int GSW = dgs_pkg::SHADE_SQ_BITS;
    localparam int IW  = dgs_pkg::SHADE_IDX_BITS;
    localparam int PW  = GSW + SW;

    dgs_pkg::back_state_t state_reg, state_next;

    logic [DB-1:0] line_prev  [MAX_WIDTH];
    logic [DB-1:0] line_prev2 [MAX_WIDTH];

    logic [DB-1:0]       cur_q, right_q, up_q;
    logic [DB-1:0]       depth_reg;
    logic [AW-1:0]       x_reg;
    dgs_pkg::pix_class_t class_reg;
    logic [DB-1:0]       left_reg;

    logic signed [DB:0]    tx_reg, ty_reg;
    logic signed [DB:0]    tx_now, ty_now;
    logic signed [SQW+1:0] txsq_full, tysq_full;
    logic [SQW-1:0]        txsq_reg, tysq_reg;
    logic [SW-1:0]         s_reg;
    logic [GW-1:0]         g_reg;
    logic [GSW-1:0]        gsq_reg;
    logic [IW-1:0]         idx_reg;

    logic [DB-1:0]  right_now;
    logic [GSW-1:0] cand_sq;
    logic [PW-1:0]  cand_prod;
    logic           cand_ok;
    logic           mem_we;
    logic           out_fire;

    // line buffers: rows j-1 and j-2, read when an entry leaves the queue
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_q   <= line_prev[pop_x];
            right_q <= line_prev[AW'(pop_x + 1'b1)];
        end
        if (mem_we)
        begin
            line_prev[x_reg] <= depth_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            up_q <= line_prev2[pop_x];
        end
        if (mem_we)
        begin
            line_prev2[x_reg] <= cur_q;
        end
    end

    // central differences
    assign right_now = class_reg.last_col ? '0 : right_q;
    assign tx_now    = $signed({1'b0, left_reg}) - $signed({1'b0, right_now});
    assign ty_now    = $signed({1'b0, up_q}) - $signed({1'b0, depth_reg});
    assign txsq_full = tx_reg * tx_reg;
    assign tysq_full = ty_reg * ty_reg;

    // (g | 2^k)^2 = g^2 + g*2^(k+1) + 2^(2k) since the lower bits of g are clear
    assign cand_sq   = gsq_reg + (GSW'(g_reg) << ({1'b0, idx_reg} + 1'b1))
                       + (GSW'(1) << {idx_reg, 1'b0});
    assign cand_prod = PW'(cand_sq) * PW'(s_reg);
    assign cand_ok   = (cand_prod <= PW'(dgs_pkg::SHADE_LIMIT));

    assign out_fire  = m_tvalid && m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dgs_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = dgs_pkg::ST_READ;
                end
            end
            dgs_pkg::ST_READ:
            begin
                if (class_reg.interior)
                begin
                    state_next = dgs_pkg::ST_SQUARE;
                end
                else if (class_reg.emit)
                begin
                    state_next = dgs_pkg::ST_OUT_PIXEL;
                end
                else
                begin
                    state_next = dgs_pkg::ST_IDLE;
                end
            end
            dgs_pkg::ST_SQUARE:
            begin
                state_next = dgs_pkg::ST_SUM;
            end
            dgs_pkg::ST_SUM:
            begin
                state_next = dgs_pkg::ST_ROOT;
            end
            dgs_pkg::ST_ROOT:
            begin
                if (idx_reg == '0)
                begin
                    state_next = dgs_pkg::ST_OUT_PIXEL;
                end
            end
            dgs_pkg::ST_OUT_PIXEL:
            begin
                if (out_fire)
                begin
                    state_next = class_reg.last_row ? dgs_pkg::ST_OUT_BORDER : dgs_pkg::ST_IDLE;
                end
            end
            dgs_pkg::ST_OUT_BORDER:
            begin
                if (out_fire)
                begin
                    state_next = dgs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        m_tvalid = 1'b0;
        m_tdata  = '0;
        m_tlast  = 1'b0;
        m_tuser  = 1'b0;
        unique case (state_reg) inside
            dgs_pkg::ST_IDLE:
            begin
                pop = !queue_empty;
            end
            dgs_pkg::ST_READ:
            begin
                mem_we = 1'b1;
            end
            dgs_pkg::ST_SQUARE, dgs_pkg::ST_SUM, dgs_pkg::ST_ROOT:
            begin
                pop = 1'b0;
            end
            dgs_pkg::ST_OUT_PIXEL:
            begin
                m_tvalid = 1'b1;
                m_tdata  = g_reg;
                m_tuser  = !class_reg.last_row;
            end
            dgs_pkg::ST_OUT_BORDER:
            begin
                m_tvalid = 1'b1;
                m_tlast  = class_reg.last_col;
                m_tuser  = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dgs_pkg::ST_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                left_reg <= cur_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            depth_reg <= pop_depth;
            x_reg     <= pop_x;
            class_reg <= pop_class;
        end
        if (state_reg == dgs_pkg::ST_READ)
        begin
            tx_reg  <= tx_now;
            ty_reg  <= ty_now;
            g_reg   <= '0;
            gsq_reg <= '0;
            idx_reg <= IW'(GW - 1);
        end
        if (state_reg == dgs_pkg::ST_SQUARE)
        begin
            txsq_reg <= SQW'(txsq_full);
            tysq_reg <= SQW'(tysq_full);
        end
        if (state_reg == dgs_pkg::ST_SUM)
        begin
            s_reg <= SW'(txsq_reg) + SW'(tysq_reg) + SW'(dgs_pkg::GRAD_BIAS);
        end
        if (state_reg == dgs_pkg::ST_ROOT)
        begin
            if (cand_ok)
            begin
                g_reg   <= g_reg | (GW'(1) << idx_reg);
                gsq_reg <= cand_sq;
            end
            idx_reg <= idx_reg - 1'b1;
        end
    end

    // running square matches the partial root throughout the search
    a_root_square: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dgs_pkg::ST_ROOT |-> gsq_reg == GSW'(g_reg) * GSW'(g_reg))
        else $error("partial root square out of step");

    // border and edge pixels come out with shade zero
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dgs_pkg::ST_OUT_PIXEL && !class_reg.interior |-> g_reg == '0)
        else $error("nonzero shade on a border pixel");

    // second result only for pixels of the last row
    a_border_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dgs_pkg::ST_OUT_BORDER |-> class_reg.last_row)
        else $error("border result outside the last row");

    // root search ends after its last bit
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dgs_pkg::ST_ROOT && idx_reg == '0 |=> state_reg == dgs_pkg::ST_OUT_PIXEL)
        else $error("root search did not finish");

    // no new entry is taken while a result is pending
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !pop)
        else $error("queue popped while a result is pending");

endmodule

// ===== rtl/depth_gradient_shading_unit.sv =====
// ----------------------------------------------------------------------------
// depth_gradient_shading_unit
// Gradient shading of a raster depth map with central differences.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in raster order, one depth per transaction;
// s_tuser marks pixel (0,0) of a frame. Shades leave on the m_ stream: the
// pixel of row j-1 above each incoming pixel of row j, and during the last
// row also that row's border pixel (shade 0) as a second transaction.
// m_tlast marks the last pixel of a frame, m_tuser the last result of an
// input pixel. Row 0 causes no output.
// Frame size is written on the cfg_ port and saturated to 3..MAX_WIDTH
// columns and 3..512 rows; the user writes it only while the stream is
// idle, the block itself does not enforce this. The front takes a pixel
// each cycle while its 2-entry queue has room; the back works on one pixel
// at a time: a row 0 pixel passes the idle and read states only, a border
// pixel then the pixel output state, an interior pixel squares, sum and
// 8-step root before that output; an extra result adds the border output
// state, and output waits stall the back. Sustained rate is set by the back.
// Reset clears the position to (0,0), the size to 512 x 512 and empties the
// queue; line buffers are not cleared. A stalled m_tready holds the current
// result and the back, and the front keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module depth_gradient_shading_unit #(
    parameter int MAX_WIDTH  = dgs_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dgs_pkg::DEPTH_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dgs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dgs_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [dgs_pkg::DEPTH_FIELD_BITS-1:0]  s_tdata,   // [7:0] depth
    input  logic                                  s_tuser,   // [0] frame_start
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dgs_pkg::SHADE_BITS-1:0]        m_tdata,   // [7:0] shade
    output logic                                  m_tlast,
    output logic                                  m_tuser    // [0] last_of_item
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CLW = $bits(dgs_pkg::pix_class_t);
    localparam int QW = CLW + AW + DEPTH_BITS;

    logic                  push;
    logic [DEPTH_BITS-1:0] push_depth;
    logic [AW-1:0]         push_x;
    dgs_pkg::pix_class_t   push_class;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  pop;
    logic [QW-1:0]         pop_data;
    dgs_pkg::pix_class_t   pop_class;

    dgs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_depth (push_depth),
        .push_x     (push_x),
        .push_class (push_class),
        .queue_full (queue_full)
    );

    dgs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_class, push_x, push_depth}),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    assign pop_class = dgs_pkg::pix_class_t'(pop_data[QW-1 -: CLW]);

    dgs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_depth   (pop_data[DEPTH_BITS-1:0]),
        .pop_x       (pop_data[DEPTH_BITS +: AW]),
        .pop_class   (pop_class),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/sv/depth_gradient_shading_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_gradient_shading_unit_test
// Streams depth maps through the shading unit and checks every shade.
// ----------------------------------------------------------------------------
// A tracker class mirrors the line buffers and the pixel position and works
// out the shades that each accepted pixel should cause. Every result taken
// from the m_ stream is checked against the oldest outstanding shade.
// Directed 3x3 frames hit flat and steep interiors, then a size change in
// mid-frame forces the position to wrap. Rows at the saturated width follow,
// then many short frames of random small sizes. Both stream sides idle at
// random and the sink chokes once for a long stretch.
// ----------------------------------------------------------------------------
module depth_gradient_shading_unit_test;

    localparam int     CLK_PERIOD     = 8;
    localparam int     TIMEOUT_CYCLES = 3_000_000;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     CHOKE_CYCLES   = 400;
    localparam int     RANDOM_PIXELS  = 450;
    localparam longint SHADE_NUM_SQ   = 1020 * 1020;

    typedef struct packed {
        logic [dgs_pkg::SHADE_BITS-1:0] shade;
        logic                           frame_end;
        logic                           last_of_item;
    } shade_result_t;

    class shade_tracker;
        bit [dgs_pkg::DEPTH_FIELD_BITS-1:0] row_above [dgs_pkg::MAX_WIDTH_DEF];
        bit [dgs_pkg::DEPTH_FIELD_BITS-1:0] row_two_above [dgs_pkg::MAX_WIDTH_DEF];
        bit [dgs_pkg::DEPTH_FIELD_BITS-1:0] held_left;
        int unsigned                        col;
        int unsigned                        row;
        logic [dgs_pkg::CFG_BITS-1:0]       width_reg;
        logic [dgs_pkg::CFG_BITS-1:0]       height_reg;
        shade_result_t                      expected_shades [$];
        int                                 mismatches;

        function new();
            held_left  = '0;
            col        = 0;
            row        = 0;
            width_reg  = dgs_pkg::DIM_RESET;
            height_reg = dgs_pkg::DIM_RESET;
            mismatches = 0;
        endfunction

        static function int clamp_dim(logic [dgs_pkg::CFG_BITS-1:0] value, int top);
            if (value < dgs_pkg::DIM_MIN)
                return int'(dgs_pkg::DIM_MIN);
            if (value > top)
                return top;
            return int'(value);
        endfunction

        // largest g in 0..255 with g*g*d <= 1020^2
        static function bit [dgs_pkg::SHADE_BITS-1:0] shade_for(longint d);
            bit [dgs_pkg::SHADE_BITS-1:0] g;
            longint                       trial;
            g = '0;
            for (int b = dgs_pkg::SHADE_BITS - 1; b >= 0; b--)
            begin
                trial = longint'(g | (8'd1 << b));
                if (trial * trial * d <= SHADE_NUM_SQ)
                    g = trial[dgs_pkg::SHADE_BITS-1:0];
            end
            return g;
        endfunction

        function void set_size(logic [dgs_pkg::CFG_INDEX_BITS-1:0] index,
                               logic [dgs_pkg::CFG_BITS-1:0] value);
            if (index == dgs_pkg::REG_IMAGE_WIDTH)
                width_reg = value;
            else if (index == dgs_pkg::REG_IMAGE_HEIGHT)
                height_reg = value;
        endfunction

        function int pending();
            return expected_shades.size();
        endfunction

        function void note_pixel(logic [dgs_pkg::DEPTH_FIELD_BITS-1:0] depth,
                                 logic frame_start);
            int unsigned                        w;
            int unsigned                        h;
            int unsigned                        x;
            int unsigned                        j;
            bit [dgs_pkg::DEPTH_FIELD_BITS-1:0] up;
            bit [dgs_pkg::DEPTH_FIELD_BITS-1:0] cur;
            bit [dgs_pkg::DEPTH_FIELD_BITS-1:0] right;
            longint                             tx;
            longint                             ty;
            shade_result_t                      res;
            w = clamp_dim(width_reg, dgs_pkg::MAX_WIDTH_DEF);
            h = clamp_dim(height_reg, int'(dgs_pkg::HEIGHT_LIMIT));
            if (frame_start)
            begin
                col = 0;
                row = 0;
            end
            // position left stale by a size change wraps
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            if (row >= h)
                row = 0;
            x     = col;
            j     = row;
            up    = row_two_above[x];
            cur   = row_above[x];
            right = (x + 1 < w) ? row_above[x + 1] : '0;
            if (j >= 1)
            begin
                // pixel (x, j-1) goes out now
                res.shade = '0;
                if (x != 0 && x != w - 1 && j != 1)
                begin
                    tx        = longint'(held_left) - longint'(right);
                    ty        = longint'(up) - longint'(depth);
                    res.shade = shade_for(4 * tx * tx + 4 * ty * ty + 16);
                end
                res.frame_end    = 1'b0;
                res.last_of_item = (j != h - 1);
                expected_shades.push_back(res);
                // last row: its own border pixel follows
                if (j == h - 1)
                begin
                    res.shade        = '0;
                    res.frame_end    = (x == w - 1);
                    res.last_of_item = 1'b1;
                    expected_shades.push_back(res);
                end
            end
            held_left        = cur;
            row_two_above[x] = cur;
            row_above[x]     = depth;
            if (x + 1 >= w)
            begin
                col = 0;
                row = (j + 1 >= h) ? 0 : j + 1;
            end
            else
            begin
                col = x + 1;
            end
        endfunction

        function void flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_shade(logic [dgs_pkg::SHADE_BITS-1:0] shade, logic frame_end,
                                  logic last_of_item);
            shade_result_t want;
            if (expected_shades.size() == 0)
            begin
                mismatches++;
                $display("%0t: shade %0d arrived with no pixel outstanding, expected none",
                         $time, shade);
                return;
            end
            want = expected_shades.pop_front();
            if (shade !== want.shade)
                flag_mismatch("shade", want.shade, shade);
            if (frame_end !== want.frame_end)
                flag_mismatch("frame_end", want.frame_end, frame_end);
            if (last_of_item !== want.last_of_item)
                flag_mismatch("last_of_item", want.last_of_item, last_of_item);
        endfunction
    endclass

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 cfg_we    = 1'b0;
    logic [dgs_pkg::CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [dgs_pkg::CFG_BITS-1:0]         cfg_data  = '0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [dgs_pkg::DEPTH_FIELD_BITS-1:0] s_tdata   = '0;   // [7:0] depth
    logic                                 s_tuser   = 1'b0; // [0] frame_start
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [dgs_pkg::SHADE_BITS-1:0]       m_tdata;          // [7:0] shade
    logic                                 m_tlast;
    logic                                 m_tuser;          // [0] last_of_item

    shade_tracker tracker = new();
    int           choke_asked = 0;
    bit           steady_rx   = 1'b0;

    depth_gradient_shading_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] next_depth(logic [7:0] prev);
        int v;
        case ($urandom_range(0, 9)) inside
            [0:3]: v = $urandom_range(0, 255);
            [4:6]:
            begin
                // smooth surface gives bright shades
                v = int'(prev) + $urandom_range(0, 6) - 3;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            [7:8]: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
            default: v = prev;
        endcase
        return v[7:0];
    endfunction

    // transactions on both sides, result checked before the new pixel is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_shade(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready)
                tracker.note_pixel(s_tdata, s_tuser);
        end
    end

    initial
    begin : result_sink
        int hold;
        int choke_done;
        hold       = 0;
        choke_done = 0;
        forever
        begin
            @(posedge clk);
            if (choke_asked != choke_done)
            begin
                choke_done++;
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                hold = steady_rx ? 0 : pick_gap();
                m_tready <= (hold == 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    task automatic write_size(input logic [dgs_pkg::CFG_BITS-1:0] wreg,
                              input logic [dgs_pkg::CFG_BITS-1:0] hreg);
        cfg_we    <= 1'b1;
        cfg_index <= dgs_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= wreg;
        @(posedge clk);
        tracker.set_size(dgs_pkg::REG_IMAGE_WIDTH, wreg);
        cfg_index <= dgs_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= hreg;
        @(posedge clk);
        tracker.set_size(dgs_pkg::REG_IMAGE_HEIGHT, hreg);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] d, input logic fs, input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= fs;
        do
            @(posedge clk);
        while (!s_tready);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // row 0 pixels give no result, so give the back end time to finish them
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [dgs_pkg::CFG_BITS-1:0] wreg,
                             input logic [dgs_pkg::CFG_BITS-1:0] hreg,
                             input int count, input bit gapless, input bit noisy,
                             input int choke_at);
        int         frame_px;
        int         pos;
        int         cut;
        logic       fs;
        logic [7:0] d;
        settle();
        write_size(wreg, hreg);
        steady_rx = ($urandom_range(0, 3) == 0);
        frame_px  = shade_tracker::clamp_dim(wreg, dgs_pkg::MAX_WIDTH_DEF)
                  * shade_tracker::clamp_dim(hreg, int'(dgs_pkg::HEIGHT_LIMIT));
        pos = 0;
        cut = frame_px;
        d   = 8'($urandom_range(0, 255));
        for (int n = 0; n < count; n++)
        begin
            if (n == choke_at)
                choke_asked++;
            if (n == 0 || pos >= cut)
            begin
                // a cut frame is always followed by a frame start
                fs  = (n == 0) || (cut < frame_px) || ($urandom_range(0, 3) != 0);
                pos = 0;
                cut = (noisy && $urandom_range(0, 6) == 0) ? $urandom_range(1, frame_px - 1)
                                                            : frame_px;
            end
            else
            begin
                fs = noisy && ($urandom_range(0, 59) == 0);
                if (fs)
                begin
                    pos = 0;
                    cut = frame_px;
                end
            end
            d = next_depth(d);
            send_pixel(d, fs, gapless ? 0 : pick_gap());
            pos++;
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] steep [9];
        int         random_pixels;
        int         count;
        steep = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frames from sizes below the minimum
        settle();
        write_size(10'd0, 10'd2);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, i == 0, pick_gap());
        // steepest gradient in both directions, frame entered by wrap-around
        for (int i = 0; i < 9; i++)
            send_pixel(steep[i], 1'b0, pick_gap());
        // frame start in mid-frame
        send_pixel(8'd17, 1'b0, 0);
        send_pixel(8'd200, 1'b0, 0);
        for (int i = 0; i < 4; i++)
            send_pixel(8'(64 * i), i == 0, pick_gap());

        // shrink the frame while the position is at column 7 of row 2
        settle();
        write_size(10'd8, 10'd8);
        for (int i = 0; i < 23; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0, pick_gap());
        settle();
        write_size(10'd5, 10'd3);
        for (int i = 0; i < 15; i++)
            send_pixel(8'($urandom_range(0, 255)), 1'b0, pick_gap());

        // saturated sizes, sink choke while row 1 streams in
        run_phase(10'd1023, 10'd600, 1024 + 64, 1'b1, 1'b0, 600);

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            count = $urandom_range(60, 200);
            run_phase(($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 2))
                                                  : 10'($urandom_range(3, 14)),
                      ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 2))
                                                  : 10'($urandom_range(3, 10)),
                      count, $urandom_range(0, 3) == 0, 1'b1, -1);
            random_pixels += count;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("depth_gradient_shading_unit_test passed");
        else
            $display("depth_gradient_shading_unit_test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("depth_gradient_shading_unit_test failed");
        $finish;
    end

endmodule
